// ----- rtl/sparse_polynomial_accumulator_top_assert.svh -----
// assertion macros used by the sparse polynomial accumulator controller
`ifndef SPARSE_POLYNOMIAL_ACCUMULATOR_TOP_ASSERT_SVH
`define SPARSE_POLYNOMIAL_ACCUMULATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SPA_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SPA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPA_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define SPA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/spa_pkg.sv -----
// shared types and codes of the sparse polynomial accumulator
package spa_pkg;

	localparam int COEF_W      = 32;
	localparam int OPCODE_W    = 2;
	localparam int STATUS_W    = 3;
	localparam int OUT_IDX_W   = 4;
	localparam int MAX_RESULTS = 16;

	localparam logic [OPCODE_W-1:0] OP_ADD   = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_MERGED    = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_CANCELLED = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_ENTRY     = 3'd4;
	localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd5;
	localparam logic [STATUS_W-1:0] STAT_CLEARED   = 3'd6;

	typedef struct packed {
		logic exp_lt;
		logic exp_eq;
		logic sum_zero;
	} alu_flags_t;

endpackage

// ----- rtl/spa_mem.sv -----
// term table storage: one write port, one registered read port
module spa_mem #(
	parameter int DEPTH = 16,
	parameter int EXP_W = 16,
	localparam int IDX_W = $clog2(DEPTH)
) (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [IDX_W-1:0]             wr_addr,
	input  logic [spa_pkg::COEF_W-1:0]   wr_coef,
	input  logic [EXP_W-1:0]             wr_exp,
	input  logic [IDX_W-1:0]             rd_addr,
	output logic [spa_pkg::COEF_W-1:0]   rd_coef,
	output logic [EXP_W-1:0]             rd_exp
);

	logic [spa_pkg::COEF_W-1:0] coef_mem [DEPTH];
	logic [EXP_W-1:0]           exp_mem [DEPTH];
	logic [spa_pkg::COEF_W-1:0] rd_coef_q;
	logic [EXP_W-1:0]           rd_exp_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			coef_mem[wr_addr] <= wr_coef;
			exp_mem[wr_addr]  <= wr_exp;
		end
		rd_coef_q <= coef_mem[rd_addr];
		rd_exp_q  <= exp_mem[rd_addr];
	end

	assign rd_coef = rd_coef_q;
	assign rd_exp  = rd_exp_q;

endmodule

// ----- rtl/spa_alu.sv -----
// shared unit: signed exponent compare and saturating coefficient add
module spa_alu #(
	parameter int EXP_W = 16
) (
	input  logic [EXP_W-1:0]           a_exp,
	input  logic [EXP_W-1:0]           b_exp,
	input  logic [spa_pkg::COEF_W-1:0] a_coef,
	input  logic [spa_pkg::COEF_W-1:0] b_coef,
	output logic [spa_pkg::COEF_W-1:0] sum,
	output spa_pkg::alu_flags_t        flags
);

	localparam int CW = spa_pkg::COEF_W;

	logic [CW:0]   wide_sum;
	logic [CW-1:0] sat_sum;

	assign wide_sum = {a_coef[CW-1], a_coef} + {b_coef[CW-1], b_coef};

	// the two top bits disagree only on overflow
	always_comb begin
		if (wide_sum[CW] != wide_sum[CW-1]) begin
			sat_sum = wide_sum[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		end else begin
			sat_sum = wide_sum[CW-1:0];
		end
	end

	assign sum            = sat_sum;
	assign flags.exp_lt   = $signed(a_exp) < $signed(b_exp);
	assign flags.exp_eq   = a_exp == b_exp;
	assign flags.sum_zero = sat_sum == '0;

endmodule

// ----- rtl/spa_ctrl.sv -----
// sequencer: table walk, shifts, read stream and output register
`include "sparse_polynomial_accumulator_top_assert.svh"
module spa_ctrl #(
	parameter int DEPTH = 16,
	parameter int EXP_W = 16,
	localparam int IDX_W = $clog2(DEPTH),
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [spa_pkg::OPCODE_W-1:0]   opcode,
	input  logic [spa_pkg::COEF_W-1:0]     term_coef,
	input  logic [EXP_W-1:0]               term_exponent,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [spa_pkg::STATUS_W-1:0]   status,
	output logic [spa_pkg::COEF_W-1:0]     out_coef,
	output logic [EXP_W-1:0]               out_exponent,
	output logic [spa_pkg::OUT_IDX_W-1:0]  out_index,
	output logic                           last,
	output logic                           mem_wr_en,
	output logic [IDX_W-1:0]               mem_wr_addr,
	output logic [spa_pkg::COEF_W-1:0]     mem_wr_coef,
	output logic [EXP_W-1:0]               mem_wr_exp,
	output logic [IDX_W-1:0]               mem_rd_addr,
	input  logic [spa_pkg::COEF_W-1:0]     mem_rd_coef,
	input  logic [EXP_W-1:0]               mem_rd_exp,
	output logic [EXP_W-1:0]               alu_b_exp,
	output logic [spa_pkg::COEF_W-1:0]     alu_b_coef,
	input  logic [spa_pkg::COEF_W-1:0]     alu_sum,
	input  spa_pkg::alu_flags_t            alu_flags
);

	typedef enum logic [6:0] {
		S_IDLE    = 7'b000_0001,
		S_SCAN    = 7'b000_0010,
		S_DN      = 7'b000_0100,
		S_UP_PREP = 7'b000_1000,
		S_UP      = 7'b001_0000,
		S_EMIT    = 7'b010_0000,
		S_RD      = 7'b100_0000
	} state_t;

	state_t state_q, state_d;

	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] n_q, n_d;
	logic [CNT_W-1:0] pos_q, pos_d;
	logic [CNT_W-1:0] i_q, i_d;
	logic [spa_pkg::COEF_W-1:0] coef_q, coef_d;
	logic [EXP_W-1:0] exp_q, exp_d;

	logic [spa_pkg::STATUS_W-1:0]  res_status_q, res_status_d;
	logic [spa_pkg::COEF_W-1:0]    res_coef_q, res_coef_d;
	logic [spa_pkg::OUT_IDX_W-1:0] res_idx_q, res_idx_d;

	logic                          out_valid_q;
	logic [spa_pkg::STATUS_W-1:0]  status_q;
	logic [spa_pkg::COEF_W-1:0]    out_coef_q;
	logic [EXP_W-1:0]              out_exp_q;
	logic [spa_pkg::OUT_IDX_W-1:0] out_idx_q;
	logic                          last_q;

	logic                          load;
	logic [spa_pkg::STATUS_W-1:0]  ld_status;
	logic [spa_pkg::COEF_W-1:0]    ld_coef;
	logic [EXP_W-1:0]              ld_exp;
	logic [spa_pkg::OUT_IDX_W-1:0] ld_idx;
	logic                          ld_last;

	logic out_free;
	logic accept;
	logic scan_end;
	logic dn_done;
	logic rd_last;

	assign out_free = !out_valid_q || !out_stall;
	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_stall = state_q != S_IDLE;

	assign alu_b_exp  = exp_q;
	assign alu_b_coef = coef_q;

	assign scan_end = (pos_q + CNT_W'(1)) == n_q;
	assign dn_done  = ((CNT_W+1)'(i_q) + (CNT_W+1)'(1)) >= (CNT_W+1)'(n_q);
	assign rd_last  = (i_q + CNT_W'(1)) == n_q;

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		n_d          = n_q;
		pos_d        = pos_q;
		i_d          = i_q;
		coef_d       = coef_q;
		exp_d        = exp_q;
		res_status_d = res_status_q;
		res_coef_d   = res_coef_q;
		res_idx_d    = res_idx_q;
		mem_wr_en    = 1'b0;
		mem_wr_addr  = IDX_W'(pos_q);
		mem_wr_coef  = coef_q;
		mem_wr_exp   = exp_q;
		mem_rd_addr  = '0;
		load         = 1'b0;
		ld_status    = res_status_q;
		ld_coef      = res_coef_q;
		ld_exp       = exp_q;
		ld_idx       = res_idx_q;
		ld_last      = 1'b1;

		case (state_q)
			S_IDLE: begin
				// entry 0 is always being read so a scan or read starts at once
				mem_rd_addr = '0;
				if (accept) begin
					coef_d = term_coef;
					exp_d  = term_exponent;
					pos_d  = '0;
					i_d    = '0;
					case (opcode)
						spa_pkg::OP_ADD: begin
							n_d     = count_q;
							state_d = (count_q == '0) ? S_UP_PREP : S_SCAN;
						end
						spa_pkg::OP_READ: begin
							if (count_q == '0) begin
								res_status_d = spa_pkg::STAT_EMPTY;
								res_coef_d   = '0;
								res_idx_d    = '0;
								exp_d        = '0;
								state_d      = S_EMIT;
							end else begin
								n_d = (32'(count_q) > spa_pkg::MAX_RESULTS) ?
									CNT_W'(spa_pkg::MAX_RESULTS) : count_q;
								state_d = S_RD;
							end
						end
						spa_pkg::OP_CLEAR: begin
							count_d      = '0;
							res_status_d = spa_pkg::STAT_CLEARED;
							res_coef_d   = '0;
							res_idx_d    = '0;
							exp_d        = '0;
							state_d      = S_EMIT;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_SCAN: begin
				// read ahead one entry; a cancel starts its shift from there
				mem_rd_addr = IDX_W'(pos_q + CNT_W'(1));
				if (alu_flags.exp_eq) begin
					if (alu_flags.sum_zero) begin
						i_d     = pos_q;
						state_d = S_DN;
					end else begin
						mem_wr_en    = 1'b1;
						mem_wr_coef  = alu_sum;
						res_status_d = spa_pkg::STAT_MERGED;
						res_coef_d   = alu_sum;
						res_idx_d    = spa_pkg::OUT_IDX_W'(pos_q);
						state_d      = S_EMIT;
					end
				end else if (alu_flags.exp_lt && !scan_end) begin
					pos_d = pos_q + CNT_W'(1);
				end else begin
					// new exponent: insert at pos or at the end past the last entry, or report a full table
					if (alu_flags.exp_lt) begin
						pos_d = n_q;
					end
					if (32'(n_q) >= DEPTH) begin
						res_status_d = spa_pkg::STAT_FULL;
						res_coef_d   = coef_q;
						res_idx_d    = '0;
						state_d      = S_EMIT;
					end else begin
						i_d     = n_q;
						state_d = S_UP_PREP;
					end
				end
			end
			S_DN: begin
				mem_rd_addr = IDX_W'(i_q + CNT_W'(2));
				if (dn_done) begin
					count_d      = n_q - CNT_W'(1);
					res_status_d = spa_pkg::STAT_CANCELLED;
					res_coef_d   = '0;
					res_idx_d    = spa_pkg::OUT_IDX_W'(pos_q);
					state_d      = S_EMIT;
				end else begin
					mem_wr_en   = 1'b1;
					mem_wr_addr = IDX_W'(i_q);
					mem_wr_coef = mem_rd_coef;
					mem_wr_exp  = mem_rd_exp;
					i_d         = i_q + CNT_W'(1);
				end
			end
			S_UP_PREP: begin
				mem_rd_addr = IDX_W'(i_q - CNT_W'(1));
				state_d     = S_UP;
			end
			S_UP: begin
				mem_rd_addr = IDX_W'(i_q - CNT_W'(2));
				mem_wr_en   = 1'b1;
				if (i_q == pos_q) begin
					mem_wr_addr  = IDX_W'(pos_q);
					count_d      = n_q + CNT_W'(1);
					res_status_d = spa_pkg::STAT_INSERTED;
					res_coef_d   = coef_q;
					res_idx_d    = spa_pkg::OUT_IDX_W'(pos_q);
					state_d      = S_EMIT;
				end else begin
					mem_wr_addr = IDX_W'(i_q);
					mem_wr_coef = mem_rd_coef;
					mem_wr_exp  = mem_rd_exp;
					i_d         = i_q - CNT_W'(1);
				end
			end
			S_EMIT: begin
				if (out_free) begin
					load    = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_RD: begin
				// hold the read address while the output word waits
				mem_rd_addr = out_free ? IDX_W'(i_q + CNT_W'(1)) : IDX_W'(i_q);
				ld_status   = spa_pkg::STAT_ENTRY;
				ld_coef     = mem_rd_coef;
				ld_exp      = mem_rd_exp;
				ld_idx      = spa_pkg::OUT_IDX_W'(i_q);
				ld_last     = rd_last;
				if (out_free) begin
					load = 1'b1;
					if (rd_last) begin
						state_d = S_IDLE;
					end else begin
						i_d = i_q + CNT_W'(1);
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		n_q          <= n_d;
		pos_q        <= pos_d;
		i_q          <= i_d;
		coef_q       <= coef_d;
		exp_q        <= exp_d;
		res_status_q <= res_status_d;
		res_coef_q   <= res_coef_d;
		res_idx_q    <= res_idx_d;
		if (load) begin
			status_q   <= ld_status;
			out_coef_q <= ld_coef;
			out_exp_q  <= ld_exp;
			out_idx_q  <= ld_idx;
			last_q     <= ld_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_coef     = out_coef_q;
	assign out_exponent = out_exp_q;
	assign out_index    = out_idx_q;
	assign last         = last_q;

	`SPA_ASSERT_RST(a_clear_empties, clk, arst_n, (accept && opcode == spa_pkg::OP_CLEAR) |=> (count_q == '0), "clear left terms in the table")
	`SPA_ASSERT_RST(a_insert_has_room, clk, arst_n, (state_q == S_UP) |-> (32'(count_q) < DEPTH), "insert shift with a full table")
	`SPA_ASSERT_RST(a_scan_in_range, clk, arst_n, (state_q == S_SCAN) |-> (pos_q < n_q), "scan ran past the last term")
	`SPA_ASSERT_RST(a_shift_dn_in_range, clk, arst_n, (state_q == S_DN) |-> (i_q >= pos_q && i_q < n_q), "remove shift out of range")

endmodule

// ----- rtl/sparse_polynomial_accumulator_top.sv -----
// add: accept, scan entries in order, then merge in place or shift entries to insert or cancel a term
// read: one word per cycle while out_stall is low, after a registered memory read
// one word at a time; the table walk through the single registered read port sets the rate
// the output register frees the input side as soon as a word is loaded
// reset (async, active low) empties the table; stored terms themselves are not cleared
module sparse_polynomial_accumulator_top #(
	parameter int TABLE_DEPTH = 16,
	parameter int EXP_WIDTH   = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [spa_pkg::OPCODE_W-1:0]   opcode,
	input  logic [spa_pkg::COEF_W-1:0]     term_coef,
	input  logic [EXP_WIDTH-1:0]           term_exponent,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [spa_pkg::STATUS_W-1:0]   status,
	output logic [spa_pkg::COEF_W-1:0]     out_coef,
	output logic [EXP_WIDTH-1:0]           out_exponent,
	output logic [spa_pkg::OUT_IDX_W-1:0]  out_index,
	output logic                           last
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);

	logic                        mem_wr_en;
	logic [IDX_W-1:0]            mem_wr_addr;
	logic [spa_pkg::COEF_W-1:0]  mem_wr_coef;
	logic [EXP_WIDTH-1:0]        mem_wr_exp;
	logic [IDX_W-1:0]            mem_rd_addr;
	logic [spa_pkg::COEF_W-1:0]  mem_rd_coef;
	logic [EXP_WIDTH-1:0]        mem_rd_exp;
	logic [EXP_WIDTH-1:0]        alu_b_exp;
	logic [spa_pkg::COEF_W-1:0]  alu_b_coef;
	logic [spa_pkg::COEF_W-1:0]  alu_sum;
	spa_pkg::alu_flags_t         alu_flags;

	spa_mem #(
		.DEPTH(TABLE_DEPTH),
		.EXP_W(EXP_WIDTH)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_coef (mem_wr_coef),
		.wr_exp  (mem_wr_exp),
		.rd_addr (mem_rd_addr),
		.rd_coef (mem_rd_coef),
		.rd_exp  (mem_rd_exp)
	);

	// stored term on the a side, incoming term on the b side
	spa_alu #(
		.EXP_W(EXP_WIDTH)
	) u_alu (
		.a_exp  (mem_rd_exp),
		.b_exp  (alu_b_exp),
		.a_coef (mem_rd_coef),
		.b_coef (alu_b_coef),
		.sum    (alu_sum),
		.flags  (alu_flags)
	);

	spa_ctrl #(
		.DEPTH(TABLE_DEPTH),
		.EXP_W(EXP_WIDTH)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.term_coef     (term_coef),
		.term_exponent (term_exponent),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.out_coef      (out_coef),
		.out_exponent  (out_exponent),
		.out_index     (out_index),
		.last          (last),
		.mem_wr_en     (mem_wr_en),
		.mem_wr_addr   (mem_wr_addr),
		.mem_wr_coef   (mem_wr_coef),
		.mem_wr_exp    (mem_wr_exp),
		.mem_rd_addr   (mem_rd_addr),
		.mem_rd_coef   (mem_rd_coef),
		.mem_rd_exp    (mem_rd_exp),
		.alu_b_exp     (alu_b_exp),
		.alu_b_coef    (alu_b_coef),
		.alu_sum       (alu_sum),
		.alu_flags     (alu_flags)
	);

endmodule

// ----- bench/sparse_polynomial_accumulator_top_tb.sv -----
// self-checking testbench of the sparse polynomial accumulator with a term table predictor
module sparse_polynomial_accumulator_top_tb;

	localparam int TABLE_DEPTH = 16;
	localparam int EXP_WIDTH = 16;
	localparam int OPCODE_W = spa_pkg::OPCODE_W;
	localparam int COEF_W = spa_pkg::COEF_W;
	localparam int STATUS_W = spa_pkg::STATUS_W;
	localparam int OUT_IDX_W = spa_pkg::OUT_IDX_W;
	localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
	localparam longint COEF_MAX = 64'sd2147483647;
	localparam longint COEF_MIN = -64'sd2147483648;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [COEF_W-1:0] coef;
		logic [EXP_WIDTH-1:0] expn;
		logic [OUT_IDX_W-1:0] pos;
		logic last;
	} term_word_t;

	class term_scoreboard;
		logic signed [COEF_W-1:0] coefs[TABLE_DEPTH];
		logic signed [EXP_WIDTH-1:0] expns[TABLE_DEPTH];
		int term_count;
		term_word_t expected_q[$];
		int errors;

		function void push(logic [STATUS_W-1:0] st, logic [COEF_W-1:0] c,
				logic [EXP_WIDTH-1:0] e, int p, logic l);
			expected_q.push_back('{status: st, coef: c, expn: e, pos: OUT_IDX_W'(p), last: l});
		endfunction

		// work out the words that one accepted input causes and update the table
		function void note_word(logic [OPCODE_W-1:0] op, logic signed [COEF_W-1:0] coef,
				logic signed [EXP_WIDTH-1:0] expn);
			int p;
			int n;
			longint sum;
			p = 0;
			case (op)
				spa_pkg::OP_ADD: begin
					while (p < term_count && expns[p] < expn)
						p++;
					if (p < term_count && expns[p] == expn) begin
						sum = longint'(coefs[p]) + longint'(coef);
						if (sum > COEF_MAX)
							sum = COEF_MAX;
						else if (sum < COEF_MIN)
							sum = COEF_MIN;
						if (sum == 0) begin
							for (int i = p; i + 1 < term_count; i++) begin
								coefs[i] = coefs[i + 1];
								expns[i] = expns[i + 1];
							end
							term_count--;
							push(spa_pkg::STAT_CANCELLED, '0, expn, p, 1'b1);
						end else begin
							coefs[p] = COEF_W'(sum);
							push(spa_pkg::STAT_MERGED, coefs[p], expn, p, 1'b1);
						end
					end else if (term_count >= TABLE_DEPTH) begin
						push(spa_pkg::STAT_FULL, coef, expn, 0, 1'b1);
					end else begin
						for (int i = term_count; i > p; i--) begin
							coefs[i] = coefs[i - 1];
							expns[i] = expns[i - 1];
						end
						coefs[p] = coef;
						expns[p] = expn;
						term_count++;
						push(spa_pkg::STAT_INSERTED, coef, expn, p, 1'b1);
					end
				end
				spa_pkg::OP_READ: begin
					n = (term_count > spa_pkg::MAX_RESULTS) ? spa_pkg::MAX_RESULTS : term_count;
					if (n == 0)
						push(spa_pkg::STAT_EMPTY, '0, '0, 0, 1'b1);
					for (int i = 0; i < n; i++)
						push(spa_pkg::STAT_ENTRY, coefs[i], expns[i], i, i + 1 == n);
				end
				spa_pkg::OP_CLEAR: begin
					term_count = 0;
					push(spa_pkg::STAT_CLEARED, '0, '0, 0, 1'b1);
				end
				default: ;
			endcase
		endfunction

		function void check_word(term_word_t got);
			term_word_t want;
			if (expected_q.size() == 0) begin
				$error("unexpected word: status %0d exponent %0d", got.status,
					$signed(got.expn));
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.coef !== want.coef) begin
				$error("out_coef: expected %0d, got %0d", $signed(want.coef),
					$signed(got.coef));
				errors++;
			end
			if (got.expn !== want.expn) begin
				$error("out_exponent: expected %0d, got %0d", $signed(want.expn),
					$signed(got.expn));
				errors++;
			end
			if (got.pos !== want.pos) begin
				$error("out_index: expected %0d, got %0d", want.pos, got.pos);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [OPCODE_W-1:0] opcode = spa_pkg::OP_ADD;
	logic [COEF_W-1:0] term_coef = '0;
	logic [EXP_WIDTH-1:0] term_exponent = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [COEF_W-1:0] out_coef;
	logic [EXP_WIDTH-1:0] out_exponent;
	logic [OUT_IDX_W-1:0] out_index;
	logic last;

	term_scoreboard board;
	int snd_idle_pct = 26;
	int rcv_stall_pct = 82;
	int hold_request = 0;
	int counted_words = 0;

	sparse_polynomial_accumulator_top #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.EXP_WIDTH(EXP_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.term_coef(term_coef),
		.term_exponent(term_exponent),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.out_coef(out_coef),
		.out_exponent(out_exponent),
		.out_index(out_index),
		.last(last)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// result side: check accepted words, then pick the stall for the next cycle
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				board.check_word('{status: status, coef: out_coef, expn: out_exponent,
					pos: out_index, last: last});
			if (hold_left == 0 && hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < rcv_stall_pct);
			end
		end
	end

	task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [COEF_W-1:0] coef,
			input logic [EXP_WIDTH-1:0] expn);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		term_coef <= coef;
		term_exponent <= expn;
		do
			@(posedge clk);
		while (in_stall);
		board.note_word(op, coef, expn);
		if (op != OP_UNUSED)
			counted_words++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.expected_q.size() != 0)
			@(posedge clk);
	endtask

	// mostly adds on a narrow exponent band so terms merge, cancel and fill the table
	task automatic random_word();
		int pick;
		int slot;
		bit from_table;
		logic [OPCODE_W-1:0] op;
		logic [COEF_W-1:0] coef;
		logic [EXP_WIDTH-1:0] expn;
		pick = $urandom_range(99);
		coef = $urandom;
		expn = EXP_WIDTH'($urandom);
		from_table = 1'b0;
		slot = (board.term_count > 0) ? $urandom_range(board.term_count - 1) : 0;
		if (pick < 8) begin
			op = spa_pkg::OP_READ;
		end else if (pick < 10) begin
			op = spa_pkg::OP_CLEAR;
		end else if (pick < 12) begin
			op = OP_UNUSED;
		end else begin
			op = spa_pkg::OP_ADD;
			pick = $urandom_range(99);
			if (pick < 40 && board.term_count > 0) begin
				expn = board.expns[slot];
				from_table = 1'b1;
			end else if (pick < 94) begin
				expn = EXP_WIDTH'(int'($urandom_range(24)) - 12);
			end
			pick = $urandom_range(99);
			if (pick < 30 && from_table)
				coef = -board.coefs[slot];
			else if (pick < 55)
				coef = {16'(int'($urandom_range(8)) - 4), 16'h0000};
			else if (pick < 65)
				coef = $urandom_range(1) ? 32'h7FFF_FFF0 + $urandom_range(15)
					: 32'h8000_0000 + $urandom_range(15);
		end
		send_word(op, coef, expn);
	endtask

	task automatic run_phase(input int snd, input int rcv, input int n);
		int stop_at;
		snd_idle_pct = snd;
		rcv_stall_pct = rcv;
		stop_at = counted_words + n;
		while (counted_words < stop_at)
			random_word();
	endtask

	initial begin
		board = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(spa_pkg::OP_READ, '0, '0);
		send_word(spa_pkg::OP_CLEAR, '0, '0);
		send_word(OP_UNUSED, 32'hA5A5_5A5A, 16'h5A5A);
		send_word(spa_pkg::OP_ADD, 32'h0000_0000, 16'h0000);
		send_word(spa_pkg::OP_ADD, 32'h7FFF_FFFF, 16'h7FFF);
		send_word(spa_pkg::OP_ADD, 32'h8000_0000, 16'h8000);
		send_word(spa_pkg::OP_ADD, 32'h0000_0001, 16'h7FFF);
		send_word(spa_pkg::OP_ADD, 32'hFFFF_FFFF, 16'h8000);
		send_word(spa_pkg::OP_ADD, 32'h0001_0000, 16'h0000);
		send_word(spa_pkg::OP_ADD, 32'hFFFF_0000, 16'h0000);
		send_word(spa_pkg::OP_ADD, 32'h0000_0003, 16'h0005);
		send_word(spa_pkg::OP_READ, '0, '0);
		send_word(spa_pkg::OP_ADD, 32'h8000_0001, 16'h7FFF);
		send_word(spa_pkg::OP_READ, '0, '0);
		send_word(spa_pkg::OP_CLEAR, '0, '0);
		send_word(spa_pkg::OP_READ, '0, '0);

		run_phase(26, 82, 64);

		// long hold on the result side while a burst of new terms overflows the table
		drain();
		send_word(spa_pkg::OP_CLEAR, '0, '0);
		snd_idle_pct = 0;
		hold_request = 300;
		for (int i = 0; i < 20; i++)
			send_word(spa_pkg::OP_ADD, $urandom, EXP_WIDTH'(i * 7 - 60));
		send_word(spa_pkg::OP_READ, '0, '0);
		drain();

		run_phase(82, 26, 64);
		run_phase(0, 0, 64);

		drain();
		repeat (2 * TABLE_DEPTH + 8) @(posedge clk);
		if (board.errors == 0 && board.expected_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/spa_pkg.sv
rtl/spa_mem.sv
rtl/spa_alu.sv
rtl/spa_ctrl.sv
rtl/sparse_polynomial_accumulator_top.sv
bench/sparse_polynomial_accumulator_top_tb.sv
